// File: rtl/core/iptp_pkg.sv
// ----------------------------------------------------------------------------
// iptp_pkg: shared types, constants and helpers
// Character codes, item kinds, precedence function and the stack cell command.
// ----------------------------------------------------------------------------
package iptp_pkg;

  localparam int SYM_W         = 8;
  localparam int STACK_DEPTH_D = 16;

  // item kind codes
  localparam logic KIND_CHAR = 1'b0;
  localparam logic KIND_END  = 1'b1;

  localparam logic [SYM_W-1:0] CH_PLUS  = 8'h2B;
  localparam logic [SYM_W-1:0] CH_MINUS = 8'h2D;
  localparam logic [SYM_W-1:0] CH_STAR  = 8'h2A;
  localparam logic [SYM_W-1:0] CH_SLASH = 8'h2F;
  localparam logic [SYM_W-1:0] CH_LPAR  = 8'h28;
  localparam logic [SYM_W-1:0] CH_RPAR  = 8'h29;

  // command broadcast to every stack cell
  typedef struct packed {
    logic push;
    logic pop;
  } stk_cmd_t;

  function automatic logic [1:0] prec(input logic [SYM_W-1:0] c);
    logic [1:0] p;
    p = 2'd0;
    if (c == CH_PLUS || c == CH_MINUS) p = 2'd1;
    if (c == CH_STAR || c == CH_SLASH) p = 2'd2;
    return p;
  endfunction

  function automatic logic is_alnum(input logic [SYM_W-1:0] c);
    return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h5A) ||
           (c >= 8'h61 && c <= 8'h7A);
  endfunction

endpackage

// File: rtl/core/iptp_if.sv
// ----------------------------------------------------------------------------
// iptp_if: channel interfaces
// Input character channel and postfix result channel, valid/ready handshake.
// ----------------------------------------------------------------------------
interface iptp_in_if import iptp_pkg::*;;
  logic             valid;
  logic             ready;
  logic             kind;
  logic [SYM_W-1:0] character;

  modport source (output valid, kind, character, input ready);
  modport sink   (input valid, kind, character, output ready);
endinterface

interface iptp_out_if import iptp_pkg::*;;
  logic             valid;
  logic             ready;
  logic [SYM_W-1:0] symbol;
  logic             has_symbol;
  logic             last;
  logic             error;

  modport source (output valid, symbol, has_symbol, last, error, input ready);
  modport sink   (input valid, symbol, has_symbol, last, error, output ready);
endinterface

// File: rtl/core/iptp_cell.sv
// ----------------------------------------------------------------------------
// iptp_cell: one operator stack entry
// Shifts in from the upper neighbor on push, from the lower one on pop.
// ----------------------------------------------------------------------------
module iptp_cell import iptp_pkg::*; (
  input  logic             clk,
  input  stk_cmd_t         cmd,
  input  logic [SYM_W-1:0] upper_i,
  input  logic [SYM_W-1:0] lower_i,
  output logic [SYM_W-1:0] data_o
);

  logic [SYM_W-1:0] data_r;
  logic [SYM_W-1:0] data_nxt;

  always_comb begin
    data_nxt = data_r;
    if (cmd.push) begin
      data_nxt = upper_i;
    end else if (cmd.pop) begin
      data_nxt = lower_i;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign data_o = data_r;

endmodule

// File: rtl/core/infix_to_postfix_converter_top.sv
// ----------------------------------------------------------------------------
// infix_to_postfix_converter_top: shunting-yard infix to postfix converter
// Operator stack built as a row of shifting cells, with a small controller.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch carries one infix character per transaction (kind 0) or an end
//   marker (kind 1) that flushes the operator stack. out_ch carries postfix
//   symbols, one per transaction; last marks the final result of an input
//   item, error flags an unmatched ')' or a stack overflow, and has_symbol 0
//   marks a result with no character (empty flush or error alone).
// Flow:
//   An item is taken in S_IDLE, registered in ch_r and worked in S_WORK.
//   Each popped operator is a step of its own, since the stack row shifts
//   one entry per cycle while the output slot is free; S_WORK returns to
//   S_IDLE once the item is finished. Each result is registered in sym_r
//   and the other output registers before out_ch shows it.
// Reset and stall:
//   rst_n clears the stack count and the controller; stack contents are
//   left as they are. When out_ch stalls, the controller holds its current
//   step and no further input is taken until the item is finished.
// ----------------------------------------------------------------------------
module infix_to_postfix_converter_top import iptp_pkg::*; #(
  parameter int STACK_DEPTH = STACK_DEPTH_D
) (
  input  logic         clk,
  input  logic         rst_n,
  iptp_in_if.sink      in_ch,
  iptp_out_if.source   out_ch
);

  localparam int CNT_W = $clog2(STACK_DEPTH + 1);

  typedef enum logic {S_IDLE, S_WORK} state_t;

  state_t           state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             emitted_r, emitted_nxt;
  logic             kind_r, kind_nxt;
  logic [SYM_W-1:0] ch_r, ch_nxt;
  logic             ov_r, ov_nxt;
  logic [SYM_W-1:0] sym_r, sym_nxt;
  logic             has_r, has_nxt;
  logic             last_r, last_nxt;
  logic             err_r, err_nxt;

  stk_cmd_t         cmd;
  logic [SYM_W-1:0] cell_q [STACK_DEPTH];

  // stack row: cell 0 is the top
  for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
    logic [SYM_W-1:0] upper;
    logic [SYM_W-1:0] lower;
    if (i == 0) begin : g_top
      assign upper = ch_r;
    end else begin : g_mid
      assign upper = cell_q[i-1];
    end
    if (i == STACK_DEPTH - 1) begin : g_bot
      assign lower = cell_q[i];
    end else begin : g_up
      assign lower = cell_q[i+1];
    end
    iptp_cell u_cell (
      .clk     (clk),
      .cmd     (cmd),
      .upper_i (upper),
      .lower_i (lower),
      .data_o  (cell_q[i])
    );
  end

  logic [SYM_W-1:0] top, nxt_top;
  logic is_end, is_opnd, is_open, is_close, is_oper;
  logic cont, more, pop_err, full, slot_free;
  logic fin_push, fin_pop, fin_err, fin_emit;

  assign top     = cell_q[0];
  assign nxt_top = cell_q[1];

  assign is_end   = (kind_r == KIND_END);
  assign is_opnd  = !is_end && is_alnum(ch_r);
  assign is_open  = !is_end && (ch_r == CH_LPAR);
  assign is_close = !is_end && (ch_r == CH_RPAR);
  assign is_oper  = !is_end && !is_opnd && !is_open && !is_close;

  // pop condition on the current top, and on the entry below it (lookahead
  // so the last pop can carry the last flag)
  assign cont = (cnt_r != '0) &&
                (is_end || (is_close && top != CH_LPAR) ||
                 (is_oper && top != CH_LPAR && prec(top) >= prec(ch_r)));
  assign more = (cnt_r > CNT_W'(1)) &&
                (is_end || (is_close && nxt_top != CH_LPAR) ||
                 (is_oper && nxt_top != CH_LPAR && prec(nxt_top) >= prec(ch_r)));
  assign pop_err = is_close && (cnt_r == CNT_W'(1));

  assign full      = (cnt_r == CNT_W'(STACK_DEPTH));
  assign slot_free = !ov_r || out_ch.ready;

  assign fin_push = (is_open || is_oper) && !full;
  assign fin_pop  = is_close && (cnt_r != '0);
  assign fin_err  = ((is_open || is_oper) && full) || (is_close && cnt_r == '0);
  assign fin_emit = !emitted_r && (is_end || is_opnd || fin_err);

  always_comb begin
    state_nxt   = state_r;
    cnt_nxt     = cnt_r;
    emitted_nxt = emitted_r;
    kind_nxt    = kind_r;
    ch_nxt      = ch_r;
    ov_nxt      = ov_r && !out_ch.ready;
    sym_nxt     = sym_r;
    has_nxt     = has_r;
    last_nxt    = last_r;
    err_nxt     = err_r;
    cmd         = '0;
    case (state_r)
      S_IDLE: begin
        if (in_ch.valid) begin
          kind_nxt    = in_ch.kind;
          ch_nxt      = in_ch.character;
          emitted_nxt = 1'b0;
          state_nxt   = S_WORK;
        end
      end
      S_WORK: begin
        if (cont) begin
          if (slot_free) begin
            ov_nxt      = 1'b1;
            sym_nxt     = top;
            has_nxt     = 1'b1;
            last_nxt    = !more;
            err_nxt     = pop_err;
            cmd.pop     = 1'b1;
            cnt_nxt     = cnt_r - CNT_W'(1);
            emitted_nxt = 1'b1;
          end
        end else if (!fin_emit || slot_free) begin
          if (fin_emit) begin
            ov_nxt   = 1'b1;
            sym_nxt  = is_opnd ? ch_r : '0;
            has_nxt  = is_opnd;
            last_nxt = 1'b1;
            err_nxt  = fin_err;
          end
          if (fin_push) begin
            cmd.push = 1'b1;
            cnt_nxt  = cnt_r + CNT_W'(1);
          end else if (fin_pop) begin
            // discard the matching '('
            cmd.pop = 1'b1;
            cnt_nxt = cnt_r - CNT_W'(1);
          end
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      cnt_r     <= '0;
      emitted_r <= 1'b0;
      ov_r      <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      cnt_r     <= cnt_nxt;
      emitted_r <= emitted_nxt;
      ov_r      <= ov_nxt;
    end
    kind_r <= kind_nxt;
    ch_r   <= ch_nxt;
    sym_r  <= sym_nxt;
    has_r  <= has_nxt;
    last_r <= last_nxt;
    err_r  <= err_nxt;
  end

  assign in_ch.ready       = (state_r == S_IDLE);
  assign out_ch.valid      = ov_r;
  assign out_ch.symbol     = sym_r;
  assign out_ch.has_symbol = has_r;
  assign out_ch.last       = last_r;
  assign out_ch.error      = err_r;

endmodule
